### hdl/lmss_pkg.sv
// ----------------------------------------------------------------------------
// lmss_pkg
// Shared types and constants for the logistic map sequence block.
// ----------------------------------------------------------------------------
package lmss_pkg;

    localparam int RATE_FRAC = 29;
    localparam int SEED_W    = 32;
    localparam int COEF_W    = 16;
    localparam int POS_W     = 6;
    localparam int STAT_W    = 2;

    typedef enum logic [STAT_W-1:0] {
        ST_OK      = 2'd0,
        ST_ORDER   = 2'd1,
        ST_LENGTH  = 2'd2
    } t_status;

    // Request as classified by the front end.
    typedef struct packed {
        logic [SEED_W-1:0] seed;
        logic [SEED_W-1:0] rate;
        logic [COEF_W-1:0] start;
        logic [COEF_W:0]   len;     // N, 1..MAX_LEN only when not error
        t_status           status;
    } t_req;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ERR,
        S_ITER,
        S_SCALE,
        S_DIV,
        S_EMIT
    } t_state;

endpackage

### hdl/lmss_front.sv
// ----------------------------------------------------------------------------
// lmss_front
// Accepts requests, checks bounds and queues them for the back end.
// ----------------------------------------------------------------------------
module lmss_front #(
    parameter int MAX_LEN = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [31:0]      i_seed,
    input  logic [31:0]      i_rate,
    input  logic [15:0]      i_start,
    input  logic [15:0]      i_end,
    output logic             o_req_valid,
    input  logic             i_req_ready,
    output lmss_pkg::t_req   o_req
);
    import lmss_pkg::*;

    // two-entry queue
    t_req       r_q [2];
    logic [1:0] r_cnt;
    logic       r_wp, r_rp;
    t_req       w_in;
    logic       w_push, w_pop;

    always_comb begin
        w_in.seed  = i_seed;
        w_in.rate  = i_rate;
        w_in.start = i_start;
        w_in.len   = {1'b0, i_end} - {1'b0, i_start};
        if (i_start > i_end) begin
            w_in.status = ST_ORDER;
        end else if (i_end == i_start ||
                     ({1'b0, i_end} - {1'b0, i_start}) > (COEF_W+1)'(MAX_LEN)) begin
            w_in.status = ST_LENGTH;
        end else begin
            w_in.status = ST_OK;
        end
    end

    assign o_ready     = (r_cnt != 2'd2);
    assign o_req_valid = (r_cnt != 2'd0);
    assign o_req       = r_q[r_rp];
    assign w_push      = i_valid && o_ready;
    assign w_pop       = o_req_valid && i_req_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) r_q[r_wp] <= w_in;
    end

endmodule

### hdl/lmss_back.sv
// ----------------------------------------------------------------------------
// lmss_back
// Iterates the map into a term buffer, then scales and emits each term
// using a restoring divider (one quotient bit per cycle).
// ----------------------------------------------------------------------------
module lmss_back #(
    parameter int MAX_LEN   = 64,
    parameter int FRAC_BITS = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    output logic              o_req_ready,
    input  lmss_pkg::t_req    i_req,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [15:0]       o_value,
    output logic [5:0]        o_pos,
    output logic              o_last,
    output logic [1:0]        o_status
);
    import lmss_pkg::*;

    localparam int FB   = FRAC_BITS;
    localparam int AW   = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int CW   = AW + 1;
    localparam int NUMW = FB + CW + 2;   // 2*N*(x-min)+d
    localparam int QW   = CW + 1;        // quotient <= N
    localparam logic [FB:0] ONE = (FB+1)'(1) << FB;

    t_state r_state, n_state;

    logic [FB-1:0]   r_mem [MAX_LEN];
    logic [FB-1:0]   r_rd;
    logic [FB-1:0]   r_x, r_min, r_max;
    logic [31:0]     r_rate;
    logic [15:0]     r_start;
    logic [CW-1:0]   r_n, r_i;
    logic [1:0]      r_phase;
    logic [2*FB-1:0] r_prod;
    logic [NUMW-1:0] r_rem;
    logic [QW-1:0]   r_quo;
    logic [$clog2(QW+1)-1:0] r_bit;
    logic [1:0]      r_err;

    logic            r_ov;
    logic [15:0]     r_ov_val;
    logic [5:0]      r_ov_pos;
    logic            r_ov_last;
    logic [1:0]      r_ov_stat;

    logic [FB-1:0]   w_d;
    logic [FB+32-1:0] w_rp;
    logic [FB-1:0]   w_y;
    logic [NUMW-1:0] w_num;
    logic [NUMW+QW-1:0] w_dsh;
    logic [FB-1:0]   w_seed_x;

    assign w_d = r_max - r_min;
    assign o_valid   = r_ov;
    assign o_value   = r_ov_val;
    assign o_pos     = r_ov_pos;
    assign o_last    = r_ov_last;
    assign o_status  = r_ov_stat;
    assign o_req_ready = (r_state == S_IDLE);

    // Q0.32 seed aligned to FB fraction bits (left shift or truncating right shift)
    assign w_seed_x = FB'({i_req.seed, {FB{1'b0}}} >> 32);

    // rate * p, then >> 29 with saturation
    assign w_rp = {32'd0, r_prod[FB-1:0]} * {{FB{1'b0}}, r_rate};
    always_comb begin
        if (w_rp[FB+32-1:RATE_FRAC] >= (FB+32-RATE_FRAC)'(ONE)) begin
            w_y = '1;
        end else begin
            w_y = w_rp[RATE_FRAC +: FB];
        end
    end

    assign w_num = (NUMW)'({r_n, 1'b0}) * (NUMW)'(r_rd - r_min) + (NUMW)'(w_d);
    assign w_dsh = {{(NUMW+QW-FB-1){1'b0}}, w_d, 1'b0} << r_bit;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_req_valid) begin
                         n_state = (i_req.status == ST_OK) ? S_ITER : S_ERR;
                     end
            S_ERR:   if (!r_ov || i_ready) n_state = S_IDLE;
            S_ITER:  if (r_i == r_n && r_phase == 2'd0) n_state = S_SCALE;
            S_SCALE: n_state = S_DIV;
            S_DIV:   if (r_bit == '0) n_state = S_EMIT;
            S_EMIT:  if (!r_ov || i_ready) begin
                         n_state = (r_i == r_n - CW'(1)) ? S_IDLE : S_SCALE;
                     end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
            r_min   <= '1;
            r_max   <= '0;
            r_x     <= '0;
        end else begin
            r_state <= n_state;
            if (r_ov && i_ready) r_ov <= 1'b0;
            case (r_state)
                S_IDLE: if (i_req_valid) begin
                    r_err   <= i_req.status;
                    r_rate  <= i_req.rate;
                    r_start <= i_req.start;
                    r_n     <= CW'(i_req.len);
                    r_i     <= CW'(1);
                    r_phase <= 2'd0;
                    if (i_req.status == ST_OK) begin
                        r_x   <= w_seed_x;
                        r_min <= w_seed_x;
                        r_max <= w_seed_x;
                    end
                end
                S_ERR: if (!r_ov || i_ready) begin
                    r_ov      <= 1'b1;
                    r_ov_val  <= '0;
                    r_ov_pos  <= '0;
                    r_ov_last <= 1'b1;
                    r_ov_stat <= r_err;
                end
                S_ITER: begin
                    // phase 0: end check; phase 1: x*(1-x); phase 2: rate multiply and store
                    case (r_phase)
                        2'd0: r_phase <= (r_i == r_n) ? 2'd0 : 2'd1;
                        2'd1: begin
                            r_prod  <= (2*FB)'(({{FB{1'b0}}, r_x} *
                                       {{FB{1'b0}}, FB'(ONE - {1'b0, r_x})}) >> FB);
                            r_phase <= 2'd2;
                        end
                        2'd2: begin
                            r_x <= w_y;
                            if (w_y < r_min) r_min <= w_y;
                            if (w_y > r_max) r_max <= w_y;
                            r_i     <= r_i + CW'(1);
                            r_phase <= 2'd0;
                        end
                        default: r_phase <= 2'd0;
                    endcase
                    if (r_i == r_n && r_phase == 2'd0) r_i <= '0;
                end
                S_SCALE: begin
                    r_rem <= w_num;
                    r_quo <= '0;
                    r_bit <= ($clog2(QW+1))'(QW - 1);
                end
                S_DIV: begin
                    if (r_rem >= NUMW'(w_dsh)) begin
                        r_rem <= r_rem - NUMW'(w_dsh);
                        r_quo[r_bit[$clog2(QW)-1:0]] <= 1'b1;
                    end
                    if (r_bit != '0) r_bit <= r_bit - 1'b1;
                end
                S_EMIT: if (!r_ov || i_ready) begin
                    r_ov      <= 1'b1;
                    r_ov_val  <= (w_d == '0) ? r_start : r_start + 16'(r_quo);
                    r_ov_pos  <= 6'(r_i);
                    r_ov_last <= (r_i == r_n - CW'(1));
                    r_ov_stat <= ST_OK;
                    r_i       <= r_i + CW'(1);
                end
                default: ;
            endcase
        end
    end

    // term buffer: write on accept and during iteration, registered read for scaling;
    // entry 0 is prefetched while iterating
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_req_valid && i_req.status == ST_OK) begin
            r_mem[0] <= w_seed_x;
        end else if (r_state == S_ITER && r_phase == 2'd2) begin
            r_mem[r_i[AW-1:0]] <= w_y;
        end
        r_rd <= r_mem[(r_state == S_EMIT) ? AW'(r_i + CW'(1)) :
                      (r_state == S_ITER) ? AW'(0) : r_i[AW-1:0]];
    end

endmodule

### hdl/logistic_map_scaled_sequence.sv
// Sequence: map iteration for the N terms, then for each term divider setup,
// eight divider bits and the output register.
// Error requests return one result from the S_ERR state once the output register is free.
// Throughput: one request at a time in the back end; the front queue holds two.
// Reset: synchronous active low; clears control, min/max; buffer not cleared.
// ----------------------------------------------------------------------------
// logistic_map_scaled_sequence
// Logistic map sequence generator with min-max scaling of each term.
// ----------------------------------------------------------------------------
module logistic_map_scaled_sequence #(
    parameter int MAX_LEN   = 64,
    parameter int FRAC_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // seed_value[31:0], rate[63:32], start_coef[79:64], end_coef[95:80]
    input  logic [95:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // scaled_value[15:0], position[21:16], status[23:22]
    output logic [23:0] m_axis_tdata,
    output logic        m_axis_tlast
);
    import lmss_pkg::*;

    t_req  w_req;
    logic  w_req_valid, w_req_ready;
    logic [15:0] w_val;
    logic [5:0]  w_pos;
    logic [1:0]  w_stat;

    lmss_front #(.MAX_LEN(MAX_LEN)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_seed      (s_axis_tdata[31:0]),
        .i_rate      (s_axis_tdata[63:32]),
        .i_start     (s_axis_tdata[79:64]),
        .i_end       (s_axis_tdata[95:80]),
        .o_req_valid (w_req_valid),
        .i_req_ready (w_req_ready),
        .o_req       (w_req)
    );

    lmss_back #(.MAX_LEN(MAX_LEN), .FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (w_req_valid),
        .o_req_ready (w_req_ready),
        .i_req       (w_req),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_value     (w_val),
        .o_pos       (w_pos),
        .o_last      (m_axis_tlast),
        .o_status    (w_stat)
    );

    assign m_axis_tdata = {w_stat, w_pos, w_val};

endmodule

### hdl/lmss_checker.sv
// ----------------------------------------------------------------------------
// lmss_checker
// Port-level checks for the logistic map sequence block.
// ----------------------------------------------------------------------------
module lmss_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic        m_axis_tlast
);
    import lmss_pkg::*;

    // error results are always single and last
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[23:22] != ST_OK |-> m_axis_tlast)
        else $error("error result without tlast");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[23:22] != ST_OK |-> m_axis_tdata[21:0] == '0)
        else $error("error result with nonzero payload");

    a_no_bad_stat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[23:22] != 2'd3)
        else $error("undefined status");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output dropped while stalled");

    // a pending request stays offered until taken
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && !s_axis_tready |=> s_axis_tvalid)
        else $error("request withdrawn while stalled");

endmodule

bind logistic_map_scaled_sequence lmss_checker u_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

### bench/logistic_map_scaled_sequence_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// logistic_map_scaled_sequence_test
// Drives seed/rate/range requests into the logistic map block, predicts each
// scaled term in fixed point and compares results in order, under random
// idling on both sides and one long output stall.
// ----------------------------------------------------------------------------
module logistic_map_scaled_sequence_test;
    import lmss_pkg::*;

    localparam int MAX_LEN   = 64;
    localparam int TIMEOUT   = 20000;

    typedef struct packed {
        logic [15:0] value;
        logic [5:0]  pos;
        logic        last;
        t_status     status;
    } t_term;

    class sequence_scoreboard;
        t_term pending[$];
        int    mismatches;
        int    terms_seen;

        function logic [31:0] next_term(logic [31:0] x, logic [31:0] r);
            logic [63:0] p;
            logic [95:0] y;
            p = 64'(({32'd0, x} * ({32'd0, 33'h1_0000_0000 - {1'b0, x}})) >> 32);
            y = ({64'd0, r} * {32'd0, p}) >> RATE_FRAC;
            if (y >= 96'h1_0000_0000) return 32'hFFFF_FFFF;
            return y[31:0];
        endfunction

        function void note_request(logic [95:0] data);
            logic [31:0] seed, r, lo, hi, d;
            logic [15:0] start, stop;
            logic [31:0] terms [MAX_LEN];
            logic [63:0] num;
            int n;
            t_term t;
            seed = data[31:0]; r = data[63:32];
            start = data[79:64]; stop = data[95:80];
            t = '0; t.last = 1'b1;
            if (start > stop) begin
                t.status = ST_ORDER; pending.push_back(t); return;
            end
            n = int'(stop) - int'(start);
            if (n == 0 || n > MAX_LEN) begin
                t.status = ST_LENGTH; pending.push_back(t); return;
            end
            terms[0] = seed; lo = seed; hi = seed;
            for (int i = 1; i < n; i++) begin
                terms[i] = next_term(terms[i-1], r);
                if (terms[i] < lo) lo = terms[i];
                if (terms[i] > hi) hi = terms[i];
            end
            d = hi - lo;
            for (int i = 0; i < n; i++) begin
                t.status = ST_OK;
                t.pos = i[5:0];
                t.last = (i == n - 1);
                if (d == 0) t.value = start;
                else begin
                    num = 64'(2 * n) * (terms[i] - lo) + d;
                    t.value = start + 16'(num / (64'd2 * d));
                end
                pending.push_back(t);
            end
        endfunction

        task check_term(logic [23:0] data, logic last);
            t_term want;
            terms_seen++;
            if (pending.size() == 0) begin
                report("unexpected term", 0, data); return;
            end
            want = pending.pop_front();
            if (data[15:0] != want.value) report("value", want.value, data[15:0]);
            if (data[21:16] != want.pos) report("position", want.pos, data[21:16]);
            if (data[23:22] != want.status) report("status", want.status, data[23:22]);
            if (last != want.last) report("tlast", want.last, last);
        endtask

        task report(string what, longint exp_v, longint got_v);
            mismatches++;
            $display("MISMATCH %s: expected %0d got %0d at %0t", what, exp_v, got_v, $time);
        endtask
    endclass

    logic        i_clk, i_rst_n;
    logic        s_axis_tvalid, s_axis_tready;
    logic [95:0] s_axis_tdata;
    logic        m_axis_tvalid, m_axis_tready;
    logic [23:0] m_axis_tdata;
    logic        m_axis_tlast;

    sequence_scoreboard sb = new();
    int  send_idle_pct, recv_idle_pct;
    bit  hold_off;
    int  quiet_cycles;
    int  requests_sent;

    logistic_map_scaled_sequence dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // receiver with random idling and an optional long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) m_axis_tready <= 1'b0;
        else m_axis_tready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_term(m_axis_tdata, m_axis_tlast);
    end

    // watchdog on cycles with no accepted request or term
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles > TIMEOUT) begin
                $display("watchdog expired");
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    // tvalid stays high after an accept until the next idle or drain
    task automatic send_request(logic [31:0] seed, logic [31:0] r,
                                logic [15:0] start, logic [15:0] stop);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {stop, start, r, seed};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_request({stop, start, r, seed});
        requests_sent++;
    endtask

    task automatic random_request();
        logic [31:0] seed, r;
        logic [15:0] start, stop;
        int kind;
        seed = $urandom();
        kind = $urandom_range(99);
        r = (kind < 10) ? 32'h8000_0000 : $urandom_range(32'h8000_0000);
        start = (kind < 50) ? 16'($urandom_range(255)) : 16'($urandom());
        if (kind < 85)
            stop = 16'(start + ($urandom_range(99) < 80 ? $urandom_range(1, 8)
                                                        : $urandom_range(9, MAX_LEN)));
        else if (kind < 92) stop = 16'($urandom());
        else stop = 16'(start + $urandom_range(MAX_LEN + 1, 200));
        if (stop < start && kind < 85) stop = start;
        send_request(seed, r, start, stop);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    initial begin
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        i_rst_n       = 1'b0;
        hold_off      = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: errors, extremes, flat and saturating sequences
        send_request(32'h1234_5678, 32'h4000_0000, 16'd10, 16'd5);
        send_request(32'h1234_5678, 32'h4000_0000, 16'hFFFF, 16'd0);
        send_request(32'h1234_5678, 32'h4000_0000, 16'd7, 16'd7);
        send_request(32'h1234_5678, 32'h4000_0000, 16'd0, 16'd65);
        send_request(32'h1234_5678, 32'h4000_0000, 16'd0, 16'hFFFF);
        send_request(32'h0, 32'h8000_0000, 16'd0, 16'd1);
        send_request(32'hFFFF_FFFF, 32'h8000_0000, 16'hFFBF, 16'hFFFF);
        send_request(32'h0, 32'h4000_0000, 16'd100, 16'd120);
        send_request(32'h8000_0000, 32'h8000_0000, 16'd0, 16'd10);
        send_request(32'h8000_0000, 32'hFFFF_FFFF, 16'd3, 16'd12);
        send_request(32'h6000_0000, 32'h5000_0000, 16'd0, 16'd64);
        send_request(32'hAAAA_AAAA, 32'h7333_3333, 16'h5555, 16'h5595);
        send_request(32'h5555_5555, 32'h0000_0001, 16'hAAAA, 16'hAAB0);
        send_request(32'h0000_0001, 32'h2000_0000, 16'd1, 16'd3);
        drain();

        send_idle_pct = 27; recv_idle_pct = 61;
        repeat (90) random_request();
        // long output stall while requests keep coming
        hold_off = 1'b1;
        fork
            begin
                int cnt;
                cnt = 0;
                while (cnt < 600) begin
                    @(posedge i_clk);
                    cnt++;
                end
                hold_off = 1'b0;
            end
            repeat (6) random_request();
        join
        send_idle_pct = 61; recv_idle_pct = 27;
        repeat (90) random_request();
        send_idle_pct = 0; recv_idle_pct = 0;
        repeat (90) random_request();
        drain();

        $display("covered %0d requests, %0d terms, incl. range errors and long stall",
                 requests_sent, sb.terms_seen);
        if (sb.mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule
